// ===== design/lpht_pkg.sv =====
`default_nettype none
package lpht_pkg;

  localparam int SLOTS      = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 64;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IDX_W      = 4;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [SLOT_W:0]   cnt_t;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_FIND   = 2'd1;
  localparam logic [1:0] FN_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] key;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [63:0]      value_out;
    logic [IDX_W-1:0] slot_index;
  } rsp_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  typedef enum logic {
    S_IDLE,
    S_PROBE
  } state_t;

endpackage
`default_nettype wire

// ===== design/lpht_ram.sv =====
`default_nettype none
module lpht_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/lpht_ctrl.sv =====
`default_nettype none
module lpht_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire lpht_pkg::req_t  req,
  output logic                 done,
  output lpht_pkg::rsp_t       rsp,
  output logic                 ram_we,
  output lpht_pkg::slot_t      ram_waddr,
  output lpht_pkg::entry_t     ram_wdata,
  output lpht_pkg::slot_t      ram_raddr,
  input  wire lpht_pkg::entry_t ram_rdata
);
  import lpht_pkg::*;

  state_t                state, state_next;
  logic [1:0]            func_r, func_r_next;
  logic [KEY_BITS-1:0]   key_r, key_r_next;
  logic [VALUE_BITS-1:0] val_r, val_r_next;
  slot_t                 s, s_next;
  slot_t                 ps, ps_next;
  logic                  pend, pend_next;
  cnt_t                  n, n_next;
  logic [SLOTS-1:0]      used, used_next;
  logic [SLOTS-1:0]      deleted, deleted_next;
  logic                  done_next;
  rsp_t                  rsp_next;
  logic [KEY_BITS-1:0]   key_in;
  slot_t                 s_adv;

  assign busy   = (state != S_IDLE);
  assign key_in = KEY_BITS'(req.key);
  assign s_adv  = (s == slot_t'(SLOTS - 1)) ? '0 : s + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pend    <= 1'b0;
      used    <= '0;
      deleted <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      pend    <= pend_next;
      used    <= used_next;
      deleted <= deleted_next;
      done    <= done_next;
    end
    func_r <= func_r_next;
    key_r  <= key_r_next;
    val_r  <= val_r_next;
    s      <= s_next;
    ps     <= ps_next;
    n      <= n_next;
    rsp    <= rsp_next;
  end

  always_comb begin
    state_next   = state;
    func_r_next  = func_r;
    key_r_next   = key_r;
    val_r_next   = val_r;
    s_next       = s;
    ps_next      = ps;
    pend_next    = pend;
    n_next       = n;
    used_next    = used;
    deleted_next = deleted;
    done_next    = 1'b0;
    rsp_next     = rsp;
    ram_we       = 1'b0;
    ram_waddr    = s;
    ram_wdata    = '{key: key_r, value: val_r};
    ram_raddr    = s;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          func_r_next = req.func;
          key_r_next  = key_in;
          val_r_next  = VALUE_BITS'(req.value);
          s_next      = slot_t'(key_in % SLOTS);
          n_next      = '0;
          pend_next   = 1'b0;
          state_next  = S_PROBE;
        end
      end
      S_PROBE: begin
        rsp_next = '{status: ST_MISS, value_out: '0, slot_index: '0};
        case (func_r) inside
          FN_INSERT: begin
            if (n == cnt_t'(SLOTS)) begin
              rsp_next.status = ST_FULL;
              done_next       = 1'b1;
              state_next      = S_IDLE;
            end else if (!used[s] || deleted[s]) begin
              ram_we              = 1'b1;
              used_next[s]        = 1'b1;
              deleted_next[s]     = 1'b0;
              rsp_next.status     = ST_OK;
              rsp_next.slot_index = IDX_W'(s);
              done_next           = 1'b1;
              state_next          = S_IDLE;
            end else begin
              s_next = s_adv;
              n_next = n + 1'b1;
            end
          end
          FN_FIND, FN_REMOVE: begin
            if (pend && ram_rdata.key == key_r) begin
              if (func_r == FN_REMOVE) begin
                deleted_next[ps] = 1'b1;
              end
              rsp_next.status     = ST_OK;
              rsp_next.value_out  = 64'(ram_rdata.value);
              rsp_next.slot_index = IDX_W'(ps);
              done_next           = 1'b1;
              state_next          = S_IDLE;
            end else if (n == cnt_t'(SLOTS) || !used[s]) begin
              done_next  = 1'b1;
              state_next = S_IDLE;
            end else begin
              // skip tombstones, issue a read for a live slot
              pend_next = !deleted[s];
              ps_next   = s;
              s_next    = s_adv;
              n_next    = n + 1'b1;
            end
          end
          default: begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/linear_probe_hash_table_top.sv =====
// channel   ports                 handshake
// request   req (func,key,value)  taken when start && !busy
// result    rsp (status,value_out,slot_index)  valid for one cycle while done
//
// An operation probes one slot per cycle until done, with the key/value RAM
// read for each live slot overlapped with the probe of the next slot.
// Used and tombstone flags live in flip-flops; rst clears them at once, no sweep.
// busy is high from the accepting edge until the cycle done is shown.
// The receiver cannot stall: done pulses once and the word is gone.
`default_nettype none
module linear_probe_hash_table_top (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire lpht_pkg::req_t req,
  output logic                done,
  output lpht_pkg::rsp_t      rsp
);
  import lpht_pkg::*;

  logic   ram_we;
  slot_t  ram_waddr;
  slot_t  ram_raddr;
  entry_t ram_wdata;
  entry_t ram_rdata;

  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  lpht_ram #(
    .DEPTH (SLOTS),
    .WIDTH ($bits(entry_t))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

// ===== design/lpht_checker.sv =====
`default_nettype none
module lpht_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           start,
  input wire logic           busy,
  input wire lpht_pkg::req_t req,
  input wire logic           done,
  input wire lpht_pkg::rsp_t rsp
);
  import lpht_pkg::*;

  logic unused_req;
  assign unused_req = ^req;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.status == ST_OK || rsp.status == ST_MISS || rsp.status == ST_FULL))
    else $error("bad status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ST_OK) |-> (rsp.value_out == '0 && rsp.slot_index == '0))
    else $error("failed operation with nonzero payload");

endmodule

bind linear_probe_hash_table_top lpht_checker u_chk (.*);
`default_nettype wire
